// ----- sv/windowed_descriptor_matcher_top_defines.svh -----
// ----------------------------------------------------------------------------
// windowed descriptor matcher assertion macros
// concurrent checks on clk, disabled while arst_n is low; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef WINDOWED_DESCRIPTOR_MATCHER_TOP_DEFINES_SVH
`define WINDOWED_DESCRIPTOR_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define WDM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define WDM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define WDM_ASSERT(lbl, prop, msg)
`define WDM_NEVER(lbl, expr, msg)
`endif

`endif

// ----- sv/wdm_pkg.sv -----
// ----------------------------------------------------------------------------
// wdm_pkg
// shared types, codes and helpers of the windowed descriptor matcher
// ----------------------------------------------------------------------------
package wdm_pkg;

	localparam int COORD_W      = 16;
	localparam int DIST_W       = 9;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int WORD_W       = 64;
	localparam int DESC_IN_BITS = 256;
	localparam int OUT_IDX_W    = 9;

	localparam logic [DIST_W-1:0]  MAX_DIST_RST = 9'd80;
	localparam logic [COORD_W-1:0] RADIUS_RST   = 16'd960;

	typedef logic [DESC_IN_BITS-1:0] desc_t;
	typedef logic [OUT_IDX_W-1:0]    match_idx_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_FRAME = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DIST = 1'b0,
		REG_RADIUS   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// controls from the sequencer to the feature store
	typedef struct packed {
		logic rd_en;
		logic wr_feat;
		logic set_used;
	} store_cmd_t;

	// controls from the sequencer to the evaluator
	typedef struct packed {
		logic start;
		logic issue;
	} eval_ctl_t;

	// status from the evaluator back to the sequencer
	typedef struct packed {
		logic busy;
		logic found;
	} eval_stat_t;

	// population count as a tree of narrow adds
	function automatic logic [DIST_W-1:0] popcount256(input desc_t v);
		logic [1:0] l1 [128];
		logic [2:0] l2 [64];
		logic [3:0] l3 [32];
		logic [4:0] l4 [16];
		logic [5:0] l5 [8];
		logic [6:0] l6 [4];
		logic [7:0] l7 [2];
		for (int i = 0; i < 128; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		for (int i = 0; i < 64; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		for (int i = 0; i < 32; i++) l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		for (int i = 0; i < 16; i++) l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		for (int i = 0; i < 8; i++) l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
		for (int i = 0; i < 4; i++) l6[i] = {1'b0, l5[2*i]} + {1'b0, l5[2*i+1]};
		for (int i = 0; i < 2; i++) l7[i] = {1'b0, l6[2*i]} + {1'b0, l6[2*i+1]};
		return {1'b0, l7[0]} + {1'b0, l7[1]};
	endfunction

endpackage

// ----- sv/wdm_store.sv -----
// ----------------------------------------------------------------------------
// wdm_store
// feature table: position, descriptor and used flag, one read and one write port
// ----------------------------------------------------------------------------
module wdm_store #(
	parameter int MAX_FEATURES = 512,
	parameter int STORE_BITS   = 256
) (
	input  logic                              clk,
	input  wdm_pkg::store_cmd_t               cmd,
	input  logic [$clog2(MAX_FEATURES)-1:0]   wr_addr,
	input  logic [$clog2(MAX_FEATURES)-1:0]   set_addr,
	input  logic [$clog2(MAX_FEATURES)-1:0]   rd_addr,
	input  logic [wdm_pkg::COORD_W-1:0]       wr_x,
	input  logic [wdm_pkg::COORD_W-1:0]       wr_y,
	input  logic [STORE_BITS-1:0]             wr_desc,
	output logic [wdm_pkg::COORD_W-1:0]       rd_x_s1,
	output logic [wdm_pkg::COORD_W-1:0]       rd_y_s1,
	output logic [STORE_BITS-1:0]             rd_desc_s1,
	output logic                              rd_used_s1
);

	localparam int IDX_W = $clog2(MAX_FEATURES);

	logic [wdm_pkg::COORD_W-1:0] x_mem_q    [MAX_FEATURES];
	logic [wdm_pkg::COORD_W-1:0] y_mem_q    [MAX_FEATURES];
	logic [STORE_BITS-1:0]       desc_mem_q [MAX_FEATURES];
	logic                        used_mem_q [MAX_FEATURES];

	logic             used_we;
	logic [IDX_W-1:0] used_addr;

	// a load stores a fresh entry with its flag clear, a match sets the flag
	assign used_we   = cmd.wr_feat || cmd.set_used;
	assign used_addr = cmd.wr_feat ? wr_addr : set_addr;

	always_ff @(posedge clk) begin
		if (cmd.wr_feat) begin
			x_mem_q[wr_addr]    <= wr_x;
			y_mem_q[wr_addr]    <= wr_y;
			desc_mem_q[wr_addr] <= wr_desc;
		end
		if (used_we) begin
			used_mem_q[used_addr] <= !cmd.wr_feat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_x_s1    <= x_mem_q[rd_addr];
			rd_y_s1    <= y_mem_q[rd_addr];
			rd_desc_s1 <= desc_mem_q[rd_addr];
			rd_used_s1 <= used_mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/wdm_eval.sv -----
// ----------------------------------------------------------------------------
// wdm_eval
// shared candidate evaluator: window test, hamming distance, running best
// ----------------------------------------------------------------------------
module wdm_eval #(
	parameter int MAX_FEATURES = 512,
	parameter int STORE_BITS   = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wdm_pkg::eval_ctl_t                ctl,
	input  logic [$clog2(MAX_FEATURES)-1:0]   issue_idx,
	input  logic [wdm_pkg::COORD_W-1:0]       pos_x,
	input  logic [wdm_pkg::COORD_W-1:0]       pos_y,
	input  logic [STORE_BITS-1:0]             desc,
	input  logic [wdm_pkg::DIST_W-1:0]        max_dist,
	input  logic [wdm_pkg::COORD_W-1:0]       radius,
	input  logic [wdm_pkg::COORD_W-1:0]       rd_x_s1,
	input  logic [wdm_pkg::COORD_W-1:0]       rd_y_s1,
	input  logic [STORE_BITS-1:0]             rd_desc_s1,
	input  logic                              rd_used_s1,
	output wdm_pkg::eval_stat_t               stat,
	output logic [wdm_pkg::DIST_W-1:0]        best_dist,
	output logic [$clog2(MAX_FEATURES)-1:0]   best_idx
);

	localparam int IDX_W = $clog2(MAX_FEATURES);
	localparam int CW    = wdm_pkg::COORD_W;
	localparam int SQ_W  = 2 * CW;

	// query held for the whole scan
	logic [CW-1:0]         qx_q;
	logic [CW-1:0]         qy_q;
	logic [STORE_BITS-1:0] qdesc_q;
	logic [SQ_W-1:0]       r2_q;

	logic                      v_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      v_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic [CW-1:0]             dx_s2;
	logic [CW-1:0]             dy_s2;
	logic [wdm_pkg::DIST_W-1:0] pop_s2;
	logic                      used_s2;
	logic                      v_s3;
	logic [IDX_W-1:0]          idx_s3;
	logic [SQ_W-1:0]           sqx_s3;
	logic [SQ_W-1:0]           sqy_s3;
	logic [wdm_pkg::DIST_W-1:0] pop_s3;
	logic                      used_s3;

	logic [wdm_pkg::DIST_W-1:0] best_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic                       found_q;

	logic [CW-1:0]              dx;
	logic [CW-1:0]              dy;
	logic [wdm_pkg::DIST_W-1:0] pop;
	logic [SQ_W:0]              d2;
	logic                       hit;

	assign dx  = (qx_q >= rd_x_s1) ? qx_q - rd_x_s1 : rd_x_s1 - qx_q;
	assign dy  = (qy_q >= rd_y_s1) ? qy_q - rd_y_s1 : rd_y_s1 - qy_q;
	assign pop = wdm_pkg::popcount256(wdm_pkg::desc_t'(qdesc_q ^ rd_desc_s1));

	// strict window and strict improvement keep the lowest index on a tie
	assign d2  = (SQ_W+1)'(sqx_s3) + (SQ_W+1)'(sqy_s3);
	assign hit = v_s3 && !used_s3 && (d2 < (SQ_W+1)'(r2_q)) && (pop_s3 < best_q);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			qx_q    <= pos_x;
			qy_q    <= pos_y;
			qdesc_q <= desc;
			r2_q    <= SQ_W'(radius) * SQ_W'(radius);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.start) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= issue_idx;
		idx_s2  <= idx_s1;
		dx_s2   <= dx;
		dy_s2   <= dy;
		pop_s2  <= pop;
		used_s2 <= rd_used_s1;
		idx_s3  <= idx_s2;
		sqx_s3  <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3  <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		pop_s3  <= pop_s2;
		used_s3 <= used_s2;
		if (ctl.start) begin
			best_q     <= max_dist;
			best_idx_q <= '0;
		end else if (hit) begin
			best_q     <= pop_s3;
			best_idx_q <= idx_s3;
		end
	end

	assign stat.busy  = v_s1 || v_s2 || v_s3;
	assign stat.found = found_q;
	assign best_dist  = best_q;
	assign best_idx   = best_idx_q;

endmodule

// ----- sv/wdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdm_ctrl
// sequencer: item intake, table fill count, scan addressing, result register
// ----------------------------------------------------------------------------
`include "windowed_descriptor_matcher_top_defines.svh"

module wdm_ctrl #(
	parameter int MAX_FEATURES = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	output wdm_pkg::store_cmd_t               cmd,
	output wdm_pkg::eval_ctl_t                ectl,
	output logic [$clog2(MAX_FEATURES)-1:0]   rd_addr,
	output logic [$clog2(MAX_FEATURES)-1:0]   wr_addr,
	input  wdm_pkg::eval_stat_t               stat,
	input  logic [wdm_pkg::DIST_W-1:0]        best_dist,
	input  logic [$clog2(MAX_FEATURES)-1:0]   best_idx,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              matched,
	output logic [wdm_pkg::OUT_IDX_W-1:0]     match_index,
	output logic [wdm_pkg::DIST_W-1:0]        match_distance,
	output logic                              table_full
);

	localparam int IDX_W = $clog2(MAX_FEATURES);
	localparam int CNT_W = $clog2(MAX_FEATURES + 1);

	wdm_pkg::state_t state_q;
	wdm_pkg::state_t state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             is_load_q;
	logic             full_q;
	logic             out_valid_q;

	logic                           matched_q;
	logic [wdm_pkg::OUT_IDX_W-1:0]  match_index_q;
	logic [wdm_pkg::DIST_W-1:0]     match_distance_q;
	logic                           table_full_q;

	logic accept;
	logic fits;
	logic scan_more;
	logic slot_free;
	logic res_load;

	assign accept    = in_valid && !in_stall;
	assign fits      = count_q < CNT_W'(MAX_FEATURES);
	assign scan_more = scan_q < count_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign rd_addr   = scan_q[IDX_W-1:0];
	assign wr_addr   = count_q[IDX_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wdm_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (op == wdm_pkg::OP_LOAD) begin
						state_d = wdm_pkg::ST_RESULT;
					end else if (op == wdm_pkg::OP_QUERY) begin
						state_d = wdm_pkg::ST_SCAN;
					end else begin
						state_d = wdm_pkg::ST_IDLE;
					end
				end
			end
			wdm_pkg::ST_SCAN: begin
				if (!scan_more) state_d = wdm_pkg::ST_DRAIN;
			end
			wdm_pkg::ST_DRAIN: begin
				if (!stat.busy) state_d = wdm_pkg::ST_RESULT;
			end
			wdm_pkg::ST_RESULT: begin
				if (slot_free) state_d = wdm_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != wdm_pkg::ST_IDLE);
		cmd      = '0;
		ectl     = '0;
		res_load = 1'b0;
		unique case (state_q)
			wdm_pkg::ST_IDLE: begin
				cmd.wr_feat = accept && (op == wdm_pkg::OP_LOAD) && fits;
				ectl.start  = accept && (op == wdm_pkg::OP_QUERY);
			end
			wdm_pkg::ST_SCAN: begin
				cmd.rd_en  = scan_more;
				ectl.issue = scan_more;
			end
			wdm_pkg::ST_DRAIN: begin
				res_load = 1'b0;
			end
			wdm_pkg::ST_RESULT: begin
				res_load     = slot_free;
				cmd.set_used = slot_free && !is_load_q && stat.found;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wdm_pkg::ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			is_load_q   <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr_feat) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && (op == wdm_pkg::OP_FRAME)) begin
				count_q <= '0;
			end
			if (ectl.start) begin
				scan_q <= '0;
			end else if (ectl.issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (accept) begin
				is_load_q <= (op == wdm_pkg::OP_LOAD);
				full_q    <= !fits;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			if (is_load_q) begin
				matched_q        <= 1'b0;
				match_index_q    <= '0;
				match_distance_q <= '0;
				table_full_q     <= full_q;
			end else begin
				matched_q        <= stat.found;
				match_index_q    <= stat.found ? wdm_pkg::match_idx_t'(best_idx) : '0;
				match_distance_q <= best_dist;
				table_full_q     <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign matched        = matched_q;
	assign match_index    = match_index_q;
	assign match_distance = match_distance_q;
	assign table_full     = table_full_q;

	`WDM_NEVER(a_count_range, count_q > CNT_W'(MAX_FEATURES), "fill count beyond table size")
	`WDM_NEVER(a_scan_range, (state_q == wdm_pkg::ST_SCAN) && (scan_q > count_q), "scan index passed fill count")
	`WDM_ASSERT(a_no_write_in_scan, (state_q == wdm_pkg::ST_SCAN || state_q == wdm_pkg::ST_DRAIN) |-> !(cmd.wr_feat || cmd.set_used), "table written during a scan")
	`WDM_ASSERT(a_out_from_result, $rose(out_valid_q) |-> $past(state_q == wdm_pkg::ST_RESULT), "result word not from result state")

endmodule

// ----- sv/windowed_descriptor_matcher_top.sv -----
// ----------------------------------------------------------------------------
// windowed_descriptor_matcher_top
// windowed hamming nearest-neighbor matcher over one frame's feature table
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | word
//  ---------+---------------------------+----------------------------------------
//  in       | in_valid / in_stall       | op, pos_x, pos_y, desc_word0..3
//  out      | out_valid / out_stall     | matched, match_index, match_distance,
//           |                           | table_full
//  cfg      | cfg_we, cfg_index         | cfg_data (write only)
//
//  load word: table write at accept, then result register
//  query word: one table entry read per cycle
//    through the single feature store port and shared evaluator pipeline
//  frame-start word: no result; op code 3 is dropped with no result
//  reset clears control state only; the table needs no clearing pass
//  a waiting result does not block intake: the next word is taken meanwhile
//
module windowed_descriptor_matcher_top #(
	parameter int MAX_FEATURES = 512,
	parameter int DESC_BITS    = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [wdm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wdm_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           op,
	input  logic [wdm_pkg::COORD_W-1:0]          pos_x,
	input  logic [wdm_pkg::COORD_W-1:0]          pos_y,
	input  logic [wdm_pkg::WORD_W-1:0]           desc_word0,
	input  logic [wdm_pkg::WORD_W-1:0]           desc_word1,
	input  logic [wdm_pkg::WORD_W-1:0]           desc_word2,
	input  logic [wdm_pkg::WORD_W-1:0]           desc_word3,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 matched,
	output logic [wdm_pkg::OUT_IDX_W-1:0]        match_index,
	output logic [wdm_pkg::DIST_W-1:0]           match_distance,
	output logic                                 table_full
);

	localparam int IDX_W = $clog2(MAX_FEATURES);
	// descriptor bits above the input word count as zero on both sides,
	// so the table only keeps the bits that can differ
	localparam int STORE_BITS = (DESC_BITS < wdm_pkg::DESC_IN_BITS) ?
		DESC_BITS : wdm_pkg::DESC_IN_BITS;

	// configuration registers
	logic [wdm_pkg::DIST_W-1:0]  max_dist_q;
	logic [wdm_pkg::COORD_W-1:0] radius_q;

	// input descriptor, trimmed to the stored width
	wdm_pkg::desc_t        desc_all;
	logic [STORE_BITS-1:0] desc_in;

	// sequencer, store and evaluator hookup
	wdm_pkg::store_cmd_t        cmd;
	wdm_pkg::eval_ctl_t         ectl;
	wdm_pkg::eval_stat_t        stat;
	logic [IDX_W-1:0]           rd_addr;
	logic [IDX_W-1:0]           wr_addr;
	logic [IDX_W-1:0]           best_idx;
	logic [wdm_pkg::DIST_W-1:0] best_dist;

	logic [wdm_pkg::COORD_W-1:0] rd_x_s1;
	logic [wdm_pkg::COORD_W-1:0] rd_y_s1;
	logic [STORE_BITS-1:0]       rd_desc_s1;
	logic                        rd_used_s1;

	assign desc_all = {desc_word3, desc_word2, desc_word1, desc_word0};
	assign desc_in  = desc_all[STORE_BITS-1:0];

	// the user must write only while the block is idle (not enforced here), so no shadowing is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= wdm_pkg::MAX_DIST_RST;
			radius_q   <= wdm_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wdm_pkg::REG_MAX_DIST: max_dist_q <= cfg_data[wdm_pkg::DIST_W-1:0];
				wdm_pkg::REG_RADIUS:   radius_q   <= cfg_data;
			endcase
		end
	end

	// sequencer: owns fill count, scan index and the result register
	wdm_ctrl #(
		.MAX_FEATURES (MAX_FEATURES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.cmd            (cmd),
		.ectl           (ectl),
		.rd_addr        (rd_addr),
		.wr_addr        (wr_addr),
		.stat           (stat),
		.best_dist      (best_dist),
		.best_idx       (best_idx),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.matched        (matched),
		.match_index    (match_index),
		.match_distance (match_distance),
		.table_full     (table_full)
	);

	// feature table; a load writes straight from the input word at accept,
	// the winning entry's used flag is set as the result is issued
	wdm_store #(
		.MAX_FEATURES (MAX_FEATURES),
		.STORE_BITS   (STORE_BITS)
	) u_store (
		.clk        (clk),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.set_addr   (best_idx),
		.rd_addr    (rd_addr),
		.wr_x       (pos_x),
		.wr_y       (pos_y),
		.wr_desc    (desc_in),
		.rd_x_s1    (rd_x_s1),
		.rd_y_s1    (rd_y_s1),
		.rd_desc_s1 (rd_desc_s1),
		.rd_used_s1 (rd_used_s1)
	);

	// shared evaluator: one candidate per cycle, window test and hamming
	// distance in three stages, running best kept across the scan
	wdm_eval #(
		.MAX_FEATURES (MAX_FEATURES),
		.STORE_BITS   (STORE_BITS)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ectl),
		.issue_idx  (rd_addr),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.desc       (desc_in),
		.max_dist   (max_dist_q),
		.radius     (radius_q),
		.rd_x_s1    (rd_x_s1),
		.rd_y_s1    (rd_y_s1),
		.rd_desc_s1 (rd_desc_s1),
		.rd_used_s1 (rd_used_s1),
		.stat       (stat),
		.best_dist  (best_dist),
		.best_idx   (best_idx)
	);

endmodule
